// File: hw/rtl/segment_circle_collision_check_core_assert.svh
// assertion macros for the collision check core
`ifndef SEGMENT_CIRCLE_COLLISION_CHECK_CORE_ASSERT_SVH
`define SEGMENT_CIRCLE_COLLISION_CHECK_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

	localparam int MAX_OBSTACLES_DEF = 64;
	localparam int SAMPLE_STEPS_DEF  = 10;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        r;
	} obstacle_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/scc_obstacle_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module scc_obstacle_mem #(
	parameter int DEPTH = scc_pkg::MAX_OBSTACLES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire scc_pkg::obstacle_t wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output scc_pkg::obstacle_t     rd_data
);

	scc_pkg::obstacle_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/scc_sample_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module scc_sample_lane #(
	parameter int SAMPLE_STEPS = scc_pkg::SAMPLE_STEPS_DEF,
	parameter int DW           = 18 + $clog2(SAMPLE_STEPS + 1)
) (
	input  wire logic                     clk,
	input  wire logic signed [DW-1:0]     px,
	input  wire logic signed [DW-1:0]     py,
	input  wire scc_pkg::obstacle_t       obs,
	output logic                          hit
);

	localparam logic signed [DW-1:0] NS = DW'(SAMPLE_STEPS);

	logic signed [DW-1:0]   cx_w;
	logic signed [DW-1:0]   cy_w;
	logic signed [DW-1:0]   ncx;
	logic signed [DW-1:0]   ncy;
	logic [DW-1:0]          nr;
	logic signed [DW-1:0]   dx_s2;
	logic signed [DW-1:0]   dy_s2;
	logic [DW-1:0]          rr_s2;
	logic signed [2*DW-1:0] dxx;
	logic signed [2*DW-1:0] dyy;
	logic [2*DW-1:0]        dxx_s3;
	logic [2*DW-1:0]        dyy_s3;
	logic [2*DW-1:0]        rrr_s3;
	logic [2*DW:0]          dist_sq;

	// scaled centre and radius, everything multiplied by the step count
	assign cx_w = DW'(obs.x);
	assign cy_w = DW'(obs.y);
	assign ncx  = NS * cx_w;
	assign ncy  = NS * cy_w;
	assign nr   = DW'(SAMPLE_STEPS) * DW'(obs.r);

	always_ff @(posedge clk) begin
		dx_s2 <= px - ncx;
		dy_s2 <= py - ncy;
		rr_s2 <= nr;
	end

	assign dxx = dx_s2 * dx_s2;
	assign dyy = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		dxx_s3 <= dxx;
		dyy_s3 <= dyy;
		rrr_s3 <= rr_s2 * rr_s2;
	end

	assign dist_sq = {1'b0, dxx_s3} + {1'b0, dyy_s3};
	assign hit     = dist_sq < {1'b0, rrr_s3};

endmodule
`default_nettype wire

// File: hw/rtl/segment_circle_collision_check_core.sv
// Segment versus circle collision checker. Obstacles (signed centre, unsigned radius,
// fixed point with 4 fraction bits) are stored by write items (command 0) into a
// single-port-write, registered-read memory; a write gives no result. A query
// item (command 1) tests SAMPLE_STEPS+1 evenly spaced points of the segment
// against the first min(obstacle_count, MAX_OBSTACLES) slots and returns
// path_free. The memory read port delivers one obstacle per cycle, tested by all
// sample lanes in parallel through a three-stage lane pipeline, so after a query
// transfer the input stays closed until the scan has drained and the result is
// loaded into the output register, which waits while the previous result is
// still held there.
// Results of queries on slots never written since reset are undefined.
// obstacle_count may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_circle_collision_check_core_assert.svh"
module segment_circle_collision_check_core #(
	parameter int MAX_OBSTACLES = scc_pkg::MAX_OBSTACLES_DEF,
	parameter int SAMPLE_STEPS  = scc_pkg::SAMPLE_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [6:0]         obstacle_count,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [5:0]         slot,
	input  wire logic signed [15:0] obstacle_x,
	input  wire logic signed [15:0] obstacle_y,
	input  wire logic [14:0]        obstacle_radius,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [15:0] end_x,
	input  wire logic signed [15:0] end_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    path_free
);

	localparam int AW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW    = $clog2(MAX_OBSTACLES + 1);
	localparam int DW    = 18 + $clog2(SAMPLE_STEPS + 1);
	localparam int LANES = SAMPLE_STEPS + 1;

	scc_pkg::state_t    state_q;
	scc_pkg::state_t    state_d;
	logic [6:0]         obstacle_count_q;
	logic [CW-1:0]      n_eff;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      last_q;
	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               hit_q;
	logic               out_valid_q;
	logic               path_free_q;
	logic               issue;
	logic               load_result;
	logic               accept;
	logic               query_accept;
	logic               wr_en;
	scc_pkg::obstacle_t wr_data;
	scc_pkg::obstacle_t rd_data;
	logic [LANES-1:0]   lane_hit;
	logic signed [DW-1:0] sx_w;
	logic signed [DW-1:0] sy_w;
	logic signed [DW-1:0] ex_w;
	logic signed [DW-1:0] ey_w;
	logic signed [DW-1:0] px_q [LANES];
	logic signed [DW-1:0] py_q [LANES];

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_count_q <= '0;
		end else if (cfg_valid) begin
			obstacle_count_q <= obstacle_count;
		end
	end

	assign n_eff = (32'(obstacle_count_q) > MAX_OBSTACLES) ? CW'(MAX_OBSTACLES)
		: CW'(obstacle_count_q);

	assign accept       = in_valid && in_ready;
	assign query_accept = accept && (command == scc_pkg::CMD_QUERY);

	// obstacle writes go straight to memory on transfer
	assign wr_en   = accept && (command == scc_pkg::CMD_WRITE)
		&& (32'(slot) < MAX_OBSTACLES);
	assign wr_data = '{x: obstacle_x, y: obstacle_y, r: obstacle_radius};

	scc_obstacle_mem #(
		.DEPTH(MAX_OBSTACLES),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(slot)),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// sample points, scaled by the step count: (N-k)*S + k*E
	assign sx_w = DW'(start_x);
	assign sy_w = DW'(start_y);
	assign ex_w = DW'(end_x);
	assign ey_w = DW'(end_y);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		localparam logic signed [DW-1:0] WA = DW'(SAMPLE_STEPS - k);
		localparam logic signed [DW-1:0] WB = DW'(k);

		always_ff @(posedge clk) begin
			if (query_accept) begin
				px_q[k] <= WA * sx_w + WB * ex_w;
				py_q[k] <= WA * sy_w + WB * ey_w;
			end
		end

		scc_sample_lane #(
			.SAMPLE_STEPS(SAMPLE_STEPS),
			.DW          (DW)
		) u_lane (
			.clk(clk),
			.px (px_q[k]),
			.py (py_q[k]),
			.obs(rd_data),
			.hit(lane_hit[k])
		);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				if (query_accept) begin
					state_d = (n_eff == '0) ? scc_pkg::ST_DONE : scc_pkg::ST_RUN;
				end
			end
			scc_pkg::ST_RUN: begin
				if (addr_q == last_q) begin
					state_d = scc_pkg::ST_DRAIN;
				end
			end
			scc_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = scc_pkg::ST_DONE;
				end
			end
			scc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = scc_pkg::ST_IDLE;
				end
			end
			default: state_d = scc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		issue       = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			scc_pkg::ST_IDLE:  in_ready    = 1'b1;
			scc_pkg::ST_RUN:   issue       = 1'b1;
			scc_pkg::ST_DRAIN: issue       = 1'b0;
			scc_pkg::ST_DONE:  load_result = !out_valid_q || out_ready;
			default:           in_ready    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_IDLE;
			addr_q  <= '0;
			last_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (query_accept) begin
				addr_q <= '0;
				last_q <= AW'(n_eff - CW'(1));
				hit_q  <= 1'b0;
			end else begin
				if (issue) begin
					addr_q <= addr_q + AW'(1);
				end
				if (v_s3 && (|lane_hit)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// output register, frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			path_free_q <= 1'b0;
		end else if (load_result) begin
			out_valid_q <= 1'b1;
			path_free_q <= !hit_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign path_free = path_free_q;

	`SCC_ASSERT_NOW(a_issue_in_range, issue, addr_q <= last_q, "read beyond last slot")
	`SCC_ASSERT_NOW(a_done_pipe_empty, state_q == scc_pkg::ST_DONE, !v_s1 && !v_s2 && !v_s3, "result taken with reads in flight")
	`SCC_ASSERT_NOW(a_idle_pipe_empty, in_ready, !v_s1 && !v_s2 && !v_s3, "input open with reads in flight")
	`SCC_ASSERT_NEXT(a_query_starts, query_accept, state_q == scc_pkg::ST_RUN || state_q == scc_pkg::ST_DONE, "query transfer did not start a scan")

endmodule
`default_nettype wire

// File: tb/sv/tb_segment_circle_collision_check_core.sv
`timescale 1ns / 1ps
module tb_segment_circle_collision_check_core;

	localparam int TABLE_DEPTH = scc_pkg::MAX_OBSTACLES_DEF;
	localparam int STEPS = scc_pkg::SAMPLE_STEPS_DEF;
	// a query holds the block for at most a scan of the full table and the pipeline drain
	localparam int QUERY_DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER = 60;
	localparam int PHASE_ITEMS = 112;
	localparam int PHASES = 8;

	typedef struct {
		logic               command;
		logic [5:0]         slot;
		logic signed [15:0] obstacle_x;
		logic signed [15:0] obstacle_y;
		logic [14:0]        obstacle_radius;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} in_item_t;

	typedef enum {ROW_CONFIG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [6:0] count_value;
		in_item_t   item;
		bit         typed;
		logic       typed_free;
	} stim_row_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_SPARSE} stall_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [6:0]         obstacle_count = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               command = scc_pkg::CMD_WRITE;
	logic [5:0]         slot = '0;
	logic signed [15:0] obstacle_x = '0;
	logic signed [15:0] obstacle_y = '0;
	logic [14:0]        obstacle_radius = '0;
	logic signed [15:0] start_x = '0;
	logic signed [15:0] start_y = '0;
	logic signed [15:0] end_x = '0;
	logic signed [15:0] end_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               path_free;

	segment_circle_collision_check_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.obstacle_count  (obstacle_count),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.slot            (slot),
		.obstacle_x      (obstacle_x),
		.obstacle_y      (obstacle_y),
		.obstacle_radius (obstacle_radius),
		.start_x         (start_x),
		.start_y         (start_y),
		.end_x           (end_x),
		.end_y           (end_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.path_free       (path_free)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the obstacle table and the count register
	scc_pkg::obstacle_t obstacle_table [TABLE_DEPTH];
	bit          slot_written [TABLE_DEPTH];
	logic [6:0]  count_setting = '0;
	logic        path_free_due [$];
	stim_row_t   directed_rows [$];

	int          fail_count = 0;
	int          burst_left = 0;
	int          results_received = 0;
	int          hold_off_left = 0;
	bit          hold_off_done = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_mode_left = 0;
	int          stall_phase = 0;
	int          quiet_cycles = 0;

	function automatic void queue_row(input stim_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic logic predict_path_free(input logic signed [15:0] sx,
			input logic signed [15:0] sy, input logic signed [15:0] ex,
			input logic signed [15:0] ey);
		longint px, py, ddx, ddy, rr;
		int     tested;
		tested = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
		for (int k = 0; k <= STEPS; k++) begin
			px = STEPS * longint'(sx) + k * (longint'(ex) - longint'(sx));
			py = STEPS * longint'(sy) + k * (longint'(ey) - longint'(sy));
			for (int i = 0; i < tested; i++) begin
				ddx = px - STEPS * longint'(obstacle_table[i].x);
				ddy = py - STEPS * longint'(obstacle_table[i].y);
				rr  = STEPS * longint'(obstacle_table[i].r);
				if (ddx * ddx + ddy * ddy < rr * rr)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic int first_unwritten(input logic [6:0] count_value);
		int tested;
		tested = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_value);
		for (int i = 0; i < tested; i++)
			if (!slot_written[i])
				return i;
		return -1;
	endfunction

	function automatic stim_row_t config_row(input int value);
		stim_row_t row;
		row = '{kind: ROW_CONFIG, count_value: value[6:0], item: '{default: '0},
			typed: 1'b0, typed_free: 1'b0};
		return row;
	endfunction

	function automatic in_item_t write_item(input int s, input int x, input int y,
			input int r, input int sx, input int sy, input int ex, input int ey);
		in_item_t it;
		it.command = scc_pkg::CMD_WRITE;
		it.slot = s[5:0];
		it.obstacle_x = x[15:0];
		it.obstacle_y = y[15:0];
		it.obstacle_radius = r[14:0];
		it.start_x = sx[15:0];
		it.start_y = sy[15:0];
		it.end_x = ex[15:0];
		it.end_y = ey[15:0];
		return it;
	endfunction

	function automatic stim_row_t write_row(input int s, input int x, input int y,
			input int r);
		stim_row_t row;
		// segment fields carry junk, a write must ignore them
		row = '{kind: ROW_ITEM, count_value: '0,
			item: write_item(s, x, y, r, 16'h5a5a, -1, 16'h7ff0, 16'h8001),
			typed: 1'b0, typed_free: 1'b0};
		return row;
	endfunction

	function automatic stim_row_t query_row(input int sx, input int sy, input int ex,
			input int ey, input bit typed, input logic typed_free);
		stim_row_t row;
		row = '{kind: ROW_ITEM, count_value: '0,
			item: write_item(6'h2a, 16'ha5a5, 16'h5a5a, 15'h2aaa, sx, sy, ex, ey),
			typed: typed, typed_free: typed_free};
		row.item.command = scc_pkg::CMD_QUERY;
		return row;
	endfunction

	// span 0 means the full 16-bit range
	function automatic logic signed [15:0] rand_coord(input int span);
		if (span == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic in_item_t random_item(input bit is_query);
		in_item_t it;
		bit       wide;
		wide = ($urandom_range(0, 4) == 0);
		it.command = is_query ? scc_pkg::CMD_QUERY : scc_pkg::CMD_WRITE;
		it.slot = 6'($urandom_range(0, TABLE_DEPTH - 1));
		it.obstacle_x = rand_coord(wide ? 0 : 3000);
		it.obstacle_y = rand_coord(wide ? 0 : 3000);
		it.obstacle_radius = wide ? 15'($urandom) : 15'($urandom_range(0, 600));
		wide = ($urandom_range(0, 4) == 0);
		it.start_x = rand_coord(wide ? 0 : 4000);
		it.start_y = rand_coord(wide ? 0 : 4000);
		it.end_x = rand_coord(wide ? 0 : 4000);
		it.end_y = rand_coord(wide ? 0 : 4000);
		return it;
	endfunction

	task automatic pace_sender();
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic push_item(input in_item_t it, input bit typed, input logic typed_free);
		logic free_now;
		in_valid <= 1'b1;
		command <= it.command;
		slot <= it.slot;
		obstacle_x <= it.obstacle_x;
		obstacle_y <= it.obstacle_y;
		obstacle_radius <= it.obstacle_radius;
		start_x <= it.start_x;
		start_y <= it.start_y;
		end_x <= it.end_x;
		end_y <= it.end_y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.command == scc_pkg::CMD_WRITE) begin
			obstacle_table[it.slot] = '{x: it.obstacle_x, y: it.obstacle_y,
				r: it.obstacle_radius};
			slot_written[it.slot] = 1'b1;
		end else begin
			free_now = predict_path_free(it.start_x, it.start_y, it.end_x, it.end_y);
			path_free_due.insert(path_free_due.size(), typed ? typed_free : free_now);
		end
	endtask

	task automatic write_obstacle_count(input logic [6:0] value);
		in_valid <= 1'b0;
		while (path_free_due.size() != 0) @(posedge clk);
		repeat (QUERY_DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		obstacle_count <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		count_setting = value;
	endtask

	initial begin
		in_item_t    it;
		int          fill_slot;
		logic [6:0]  phase_counts [PHASES];

		queue_row(config_row(0));
		// zero count: always free
		queue_row(query_row(-32768, -32768, 32767, 32767, 1'b1, 1'b1));
		queue_row(write_row(0, -32768, -32768, 32767));
		queue_row(write_row(1, 32767, 32767, 0));
		queue_row(write_row(2, 32767, -32768, 1));
		queue_row(write_row(3, 100, 100, 16));
		queue_row(write_row(63, -1, -1, 15'h5555));
		queue_row(config_row(1));
		// point on the centre of the largest obstacle
		queue_row(query_row(-32768, -32768, -32768, -32768, 1'b1, 1'b0));
		queue_row(query_row(0, 0, 0, 0, 1'b0, 1'b0));
		queue_row(query_row(-32768, 32767, 32767, -32768, 1'b0, 1'b0));
		queue_row(config_row(2));
		// zero radius never collides
		queue_row(query_row(32767, 32767, 32767, 32767, 1'b1, 1'b1));
		queue_row(config_row(4));
		queue_row(query_row(32767, -32768, 32767, -32768, 1'b0, 1'b0));
		// exactly on the rim is not inside
		queue_row(query_row(116, 100, 116, 100, 1'b0, 1'b0));
		queue_row(query_row(115, 100, 115, 100, 1'b0, 1'b0));
		// only the middle sample lands inside
		queue_row(query_row(0, 100, 200, 100, 1'b0, 1'b0));
		// samples step over the small obstacle
		queue_row(query_row(0, 100, 2000, 100, 1'b0, 1'b0));
		queue_row(query_row(32767, 32767, -32768, -32768, 1'b0, 1'b0));

		phase_counts = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd100, 7'd0, 7'd0, 7'd0};
		for (int p = 5; p < PHASES; p++)
			phase_counts[p] = 7'($urandom_range(2, 16));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				write_obstacle_count(directed_rows[i].count_value);
			end else begin
				pace_sender();
				push_item(directed_rows[i].item, directed_rows[i].typed,
					directed_rows[i].typed_free);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_obstacle_count(phase_counts[p]);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				it = random_item($urandom_range(0, 99) < 65);
				// a query may only touch written slots, so fill the gap first
				fill_slot = first_unwritten(count_setting);
				if (it.command == scc_pkg::CMD_QUERY && fill_slot >= 0) begin
					it.command = scc_pkg::CMD_WRITE;
					it.slot = 6'(fill_slot);
				end
				pace_sender();
				push_item(it, 1'b0, 1'b0);
			end
		end

		in_valid <= 1'b0;
		while (path_free_due.size() != 0) @(posedge clk);
		repeat (QUERY_DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && path_free_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// result side: check, then pick next ready
	initial begin
		logic want;
		logic due;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_received++;
				if (path_free_due.size() == 0) begin
					$error("path_free result with no expectation waiting, actual %0b",
						path_free);
					fail_count++;
				end else begin
					due = path_free_due.pop_front();
					if (path_free !== due) begin
						$error("path_free mismatch: expected %0b, actual %0b", due,
							path_free);
						fail_count++;
					end
				end
			end
			// long hold-off so the block backs up and stalls its input
			if (!hold_off_done && results_received >= HOLD_OFF_AFTER) begin
				hold_off_done = 1'b1;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (stall_mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				stall_mode_left = $urandom_range(32, 256);
			end
			stall_mode_left--;
			stall_phase++;
			if (hold_off_left > 0) begin
				hold_off_left--;
				want = 1'b0;
			end else begin
				case (stall_mode)
					STALL_NONE: want = 1'b1;
					STALL_RANDOM: want = 1'($urandom_range(0, 1));
					default: want = (stall_phase % 4 == 0);
				endcase
			end
			out_ready <= want;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
